// ===== rtl/core/mmcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcm_pkg
// Shared widths, constants, command struct and palette of the colormap unit.
// ----------------------------------------------------------------------------
package mmcm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int IDX_FRAC    = 8;
	localparam int Q_BITS      = IDX_FRAC + 4;
	localparam int IDX_TOP     = 9 * (1 << IDX_FRAC);
	localparam int NUM_BITS    = SAMPLE_BITS + Q_BITS;
	localparam int STEP_BITS   = $clog2(Q_BITS);
	localparam int COLOR_BITS  = 8;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	localparam logic [COLOR_BITS-1:0] ALPHA_NORMAL = 8'd200;
	localparam logic [COLOR_BITS-1:0] ALPHA_TOP    = 8'd128;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_start;
		logic div_step;
		logic emit;
	} ctrl_cmd_t;

	typedef logic [3*COLOR_BITS-1:0] rgb_t;

	// ten-entry palette, packed as {red, green, blue}
	function automatic rgb_t palette_color(input logic [3:0] k);
		rgb_t c;
		unique case (k)
			4'd0: c = {8'd0,   8'd0,   8'd4};
			4'd1: c = {8'd31,  8'd12,  8'd72};
			4'd2: c = {8'd85,  8'd15,  8'd109};
			4'd3: c = {8'd135, 8'd23,  8'd126};
			4'd4: c = {8'd177, 8'd42,  8'd124};
			4'd5: c = {8'd208, 8'd70,  8'd107};
			4'd6: c = {8'd225, 8'd104, 8'd85};
			4'd7: c = {8'd237, 8'd142, 8'd63};
			4'd8: c = {8'd248, 8'd184, 8'd45};
			default: c = {8'd252, 8'd231, 8'd37};
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mmcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcm_in_if / mmcm_out_if
// Valid/ready channels carrying sample items in and color items out.
// ----------------------------------------------------------------------------
interface mmcm_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   operation;
	logic                                   first_of_frame;
	logic signed [mmcm_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, operation, first_of_frame, sample, input ready);
	modport sink (input valid, operation, first_of_frame, sample, output ready);
endinterface

interface mmcm_out_if;
	logic                              valid;
	logic                              ready;
	logic [mmcm_pkg::COLOR_BITS-1:0]   red;
	logic [mmcm_pkg::COLOR_BITS-1:0]   green;
	logic [mmcm_pkg::COLOR_BITS-1:0]   blue;
	logic [mmcm_pkg::COLOR_BITS-1:0]   alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/minmax_normalized_colormap_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// minmax_normalized_colormap_unit
// Heatmap coloring of a signed Q8.8 scalar frame streamed twice.
// ----------------------------------------------------------------------------
// samples: sink channel. operation selects scan (fold the sample into the
//   running frame min/max, first_of_frame restarts them) or map.
// colors: source channel, one item per map item, none per scan item.
// A scan item updates the frame min/max as it is taken; the next item can
// follow right after. A map item passes the prepare state (offset, range,
// product by 9*256), the divider load state, the restoring divider that
// yields the 12-bit palette index, and the blend into the output register.
// The input is ready again only once the unit is back in idle, so the next
// item is not taken before a map item is through. Items are handled one at
// a time.
// The result waits in the output register while colors is stalled; the unit
// still accepts the next item and holds its finished result until the slot
// frees. Reset clears the frame min/max to zero and empties the output.
// ----------------------------------------------------------------------------
module minmax_normalized_colormap_unit (
	input  wire          clk,
	input  wire          arst_n,
	mmcm_in_if.sink      samples,
	mmcm_out_if.source   colors
);

	mmcm_pkg::ctrl_cmd_t cmd;

	mmcm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (samples.valid),
		.in_operation (samples.operation),
		.in_ready     (samples.ready),
		.out_ready    (colors.ready),
		.out_valid    (colors.valid),
		.cmd          (cmd)
	);

	mmcm_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.in_operation      (samples.operation),
		.in_first_of_frame (samples.first_of_frame),
		.in_sample         (samples.sample),
		.red               (colors.red),
		.green             (colors.green),
		.blue              (colors.blue),
		.alpha             (colors.alpha)
	);

endmodule
`default_nettype wire

// ===== rtl/core/mmcm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcm_ctrl
// Sequencer: accepts items, steps the datapath through prepare, divide and
// blend, and owns the output valid flag.
// ----------------------------------------------------------------------------
module mmcm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_operation,
	output logic                 in_ready,
	input  wire                  out_ready,
	output logic                 out_valid,
	output mmcm_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIVI = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                     state_q;
	logic [2:0]                     state_d;
	logic [mmcm_pkg::STEP_BITS-1:0] step_q;
	logic                           out_valid_q;
	logic                           slot_free;
	logic                           last_step;

	assign slot_free = !out_valid_q || out_ready;
	assign last_step = (step_q == mmcm_pkg::STEP_BITS'(mmcm_pkg::Q_BITS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_operation == mmcm_pkg::OP_MAP) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIVI;
			end
			ST_DIVI: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/mmcm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmcm_datapath
// Frame extremes, normalizing divider and palette blend with output register.
// ----------------------------------------------------------------------------
module mmcm_datapath (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  mmcm_pkg::ctrl_cmd_t                    cmd,
	input  wire                                    in_operation,
	input  wire                                    in_first_of_frame,
	input  wire signed [mmcm_pkg::SAMPLE_BITS-1:0] in_sample,
	output logic [mmcm_pkg::COLOR_BITS-1:0]        red,
	output logic [mmcm_pkg::COLOR_BITS-1:0]        green,
	output logic [mmcm_pkg::COLOR_BITS-1:0]        blue,
	output logic [mmcm_pkg::COLOR_BITS-1:0]        alpha
);

	localparam int SB = mmcm_pkg::SAMPLE_BITS;
	localparam int QB = mmcm_pkg::Q_BITS;
	localparam int NB = mmcm_pkg::NUM_BITS;
	localparam int CB = mmcm_pkg::COLOR_BITS;

	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic signed [SB-1:0] sample_q;
	logic [SB-1:0]        range_q;
	logic                 zero_q;
	logic                 top_q;
	logic [NB-1:0]        num_q;
	logic [SB-1:0]        rem_q;
	logic [QB-1:0]        num_lo_q;
	logic [QB-1:0]        quo_q;

	logic signed [SB:0]   diff;
	logic signed [SB:0]   span;
	logic [SB-1:0]        range_d;
	logic [SB:0]          rem_shift;
	logic                 rem_ge;
	logic [SB:0]          rem_sub;
	logic [QB-1:0]        q_idx;
	logic [3:0]           k_idx;
	logic [7:0]           frac;
	mmcm_pkg::rgb_t       c_lo;
	mmcm_pkg::rgb_t       c_hi;

	function automatic logic [CB-1:0] blend(input logic [CB-1:0] lo, input logic [CB-1:0] hi,
			input logic [7:0] f);
		logic signed [CB+9:0] acc;
		acc = $signed({2'b00, lo, 8'h00})
			+ $signed({{(CB+1){1'b0}}, f}) * ($signed({2'b00, hi}) - $signed({2'b00, lo}));
		if (acc < 0) begin
			return '0;
		end
		return acc[CB+7:8];
	endfunction

	assign diff    = (SB+1)'(sample_q) - (SB+1)'(min_q);
	assign span    = (SB+1)'(max_q) - (SB+1)'(min_q);
	// an empty range counts as one unit
	assign range_d = (span <= 0) ? SB'(1 << mmcm_pkg::FRAC_BITS) : span[SB-1:0];

	assign rem_shift = {rem_q, num_lo_q[QB-1]};
	assign rem_ge    = (rem_shift >= {1'b0, range_q});
	assign rem_sub   = rem_shift - {1'b0, range_q};

	always_comb begin
		if (top_q) begin
			q_idx = QB'(mmcm_pkg::IDX_TOP);
		end else if (zero_q) begin
			q_idx = '0;
		end else begin
			q_idx = quo_q;
		end
		k_idx = q_idx[QB-1:8];
		if (k_idx > 4'd8) begin
			k_idx = 4'd8;
		end
		frac = q_idx[7:0];
		c_lo = mmcm_pkg::palette_color(k_idx);
		c_hi = mmcm_pkg::palette_color(k_idx + 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (cmd.load && in_operation == mmcm_pkg::OP_SCAN) begin
			if (in_first_of_frame) begin
				min_q <= in_sample;
				max_q <= in_sample;
			end else begin
				if (in_sample < min_q) begin
					min_q <= in_sample;
				end
				if (in_sample > max_q) begin
					max_q <= in_sample;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_sample;
		end
		if (cmd.prep) begin
			range_q <= range_d;
			zero_q  <= (diff <= 0);
			top_q   <= (diff > 0) && (diff >= $signed({1'b0, range_d}));
			num_q   <= NB'(diff[SB-1:0]) * NB'(mmcm_pkg::IDX_TOP);
		end
		// long division: quotient fits in QB bits so the high part starts below range
		if (cmd.div_start) begin
			rem_q    <= num_q[NB-1:QB];
			num_lo_q <= num_q[QB-1:0];
			quo_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q    <= rem_ge ? rem_sub[SB-1:0] : rem_shift[SB-1:0];
			num_lo_q <= {num_lo_q[QB-2:0], 1'b0};
			quo_q    <= {quo_q[QB-2:0], rem_ge};
		end
		if (cmd.emit) begin
			if (q_idx >= QB'(mmcm_pkg::IDX_TOP)) begin
				red   <= c_hi[3*CB-1:2*CB];
				green <= c_hi[2*CB-1:CB];
				blue  <= c_hi[CB-1:0];
				alpha <= mmcm_pkg::ALPHA_TOP;
			end else begin
				red   <= blend(c_lo[3*CB-1:2*CB], c_hi[3*CB-1:2*CB], frac);
				green <= blend(c_lo[2*CB-1:CB], c_hi[2*CB-1:CB], frac);
				blue  <= blend(c_lo[CB-1:0], c_hi[CB-1:0], frac);
				alpha <= mmcm_pkg::ALPHA_NORMAL;
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/minmax_normalized_colormap_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_normalized_colormap_unit_tb
// Streams scan and map sample items through the colormap unit and checks
// every color item against a local min/max tracker and palette blender.
// Directed edge cases come first, then random frames that are scanned and
// then mapped, with noise items, random idling on both channels, a long
// output stall and pauses until all colors have drained.
// ----------------------------------------------------------------------------
module minmax_normalized_colormap_unit_tb;

	localparam int SB = mmcm_pkg::SAMPLE_BITS;
	localparam int CB = mmcm_pkg::COLOR_BITS;

	localparam int TOP_INDEX  = 9 * 256;
	localparam int ONE_UNIT   = 256;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 40;

	localparam logic [7:0] ALPHA_BLEND = 8'd200;
	localparam logic [7:0] ALPHA_PEAK  = 8'd128;

	// heat palette, entry 9 first, each {red, green, blue}
	localparam logic [9:0][23:0] HEAT_PAL = {
		{8'd252, 8'd231, 8'd37},
		{8'd248, 8'd184, 8'd45},
		{8'd237, 8'd142, 8'd63},
		{8'd225, 8'd104, 8'd85},
		{8'd208, 8'd70,  8'd107},
		{8'd177, 8'd42,  8'd124},
		{8'd135, 8'd23,  8'd126},
		{8'd85,  8'd15,  8'd109},
		{8'd31,  8'd12,  8'd72},
		{8'd0,   8'd0,   8'd4}
	};

	typedef struct packed {
		logic                 operation;
		logic                 first_of_frame;
		logic signed [SB-1:0] sample;
	} sample_item_t;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
		logic [CB-1:0] alpha;
	} color_t;

	logic clk;
	logic arst_n;

	mmcm_in_if  samples ();
	mmcm_out_if colors ();

	minmax_normalized_colormap_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.colors  (colors)
	);

	sample_item_t pending[$];
	color_t       colors_due[$];

	logic signed [SB-1:0] frame_lo;
	logic signed [SB-1:0] frame_hi;

	bit idle_on;
	int hold_request;
	int hold_served;
	int queued;
	int taken;
	int scans_taken;
	int maps_taken;
	int colors_checked;
	int frames;
	int errors;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// color that a map item gets against the current frame extremes
	function automatic color_t heat_color(input logic signed [SB-1:0] s);
		int span, offset, idx, k, f, c, lo_v, hi_v, acc;
		logic [23:0] rgb;
		color_t res;
		span = frame_hi - frame_lo;
		if (span <= 0)
			span = ONE_UNIT;
		offset = s - frame_lo;
		if (offset <= 0)
			idx = 0;
		else if (offset >= span)
			idx = TOP_INDEX;
		else
			idx = offset * TOP_INDEX / span;
		if (idx >= TOP_INDEX) begin
			res = {HEAT_PAL[9], ALPHA_PEAK};
		end else begin
			k = idx >> 8;
			f = idx & 255;
			for (c = 0; c < 3; c++) begin
				lo_v = HEAT_PAL[k][c*8 +: 8];
				hi_v = HEAT_PAL[k+1][c*8 +: 8];
				acc = lo_v * 256 + f * (hi_v - lo_v);
				rgb[c*8 +: 8] = 8'(acc >> 8);
			end
			res = {rgb, ALPHA_BLEND};
		end
		return res;
	endfunction

	task automatic track_item(input sample_item_t it);
		if (it.operation == mmcm_pkg::OP_SCAN) begin
			scans_taken++;
			if (it.first_of_frame) begin
				frame_lo = it.sample;
				frame_hi = it.sample;
			end else begin
				if (it.sample < frame_lo)
					frame_lo = it.sample;
				if (it.sample > frame_hi)
					frame_hi = it.sample;
			end
		end else begin
			maps_taken++;
			colors_due.push_back(heat_color(it.sample));
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		sample_item_t nxt;
		int gap_left;
		if (!arst_n) begin
			samples.valid          <= 1'b0;
			samples.operation      <= mmcm_pkg::OP_SCAN;
			samples.first_of_frame <= 1'b0;
			samples.sample         <= '0;
			gap_left = 0;
		end else begin
			if (samples.valid && samples.ready) begin
				track_item({samples.operation, samples.first_of_frame, samples.sample});
				taken++;
			end
			if (!samples.valid || samples.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					samples.valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 15);
					samples.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					nxt = pending.pop_front();
					samples.valid          <= 1'b1;
					samples.operation      <= nxt.operation;
					samples.first_of_frame <= nxt.first_of_frame;
					samples.sample         <= nxt.sample;
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		color_t got, want;
		int hold_left, stall_left;
		if (!arst_n) begin
			colors.ready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (colors.valid && colors.ready) begin
				got = {colors.red, colors.green, colors.blue, colors.alpha};
				if (colors_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected color item r=%0d g=%0d b=%0d a=%0d",
						$time, got.red, got.green, got.blue, got.alpha);
				end else begin
					want = colors_due.pop_front();
					colors_checked++;
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
							$time, want.red, want.green, want.blue, want.alpha,
							got.red, got.green, got.blue, got.alpha);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				colors.ready <= 1'b0;
			end else if (hold_served != hold_request) begin
				hold_served++;
				hold_left = LONG_HOLD - 1;
				colors.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				colors.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				colors.ready <= 1'b0;
			end else begin
				colors.ready <= 1'b1;
			end
		end
	end

	task automatic queue_item(input logic op, input logic fof,
			input logic signed [SB-1:0] s);
		sample_item_t it;
		it.operation = op;
		it.first_of_frame = fof;
		it.sample = s;
		pending.push_back(it);
		queued++;
	endtask

	// one frame scanned, then streamed again for mapping
	task automatic queue_frame();
		logic signed [SB-1:0] vals[$];
		logic signed [SB-1:0] base, v;
		int n, spread, i;
		n = $urandom_range(1, 12);
		base = SB'($urandom);
		case ($urandom_range(0, 3))
			0: spread = 65535;
			1: spread = $urandom_range(1, 300);
			2: spread = 0;
			default: spread = $urandom_range(300, 6000);
		endcase
		for (i = 0; i < n; i++) begin
			v = SB'(base + $urandom_range(0, spread));
			vals.push_back(v);
			queue_item(mmcm_pkg::OP_SCAN, (i == 0) || ($urandom_range(0, 19) == 0), v);
		end
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: v = SB'($urandom);
				1: v = SB'(vals[i] + $urandom_range(0, 4) - 2);
				default: v = vals[i];
			endcase
			queue_item(mmcm_pkg::OP_MAP, 1'($urandom_range(0, 1)), v);
		end
		frames++;
	endtask

	task automatic queue_random(input int count);
		int target;
		target = queued + count;
		while (queued < target) begin
			if ($urandom_range(0, 6) == 0)
				queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					SB'($urandom));
			else
				queue_frame();
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (taken != queued || colors_due.size() != 0);
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.operation = mmcm_pkg::OP_SCAN;
		samples.first_of_frame = 1'b0;
		samples.sample = '0;
		colors.ready = 1'b0;
		frame_lo = '0;
		frame_hi = '0;
		idle_on = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// extremes still zero: zero range counts as one unit
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0000);
		queue_item(mmcm_pkg::OP_MAP, 1'b1, 16'h0080);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h00FF);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0100);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h8000);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h7FFF);
		// full-scale frame
		queue_item(mmcm_pkg::OP_SCAN, 1'b1, 16'h8000);
		queue_item(mmcm_pkg::OP_SCAN, 1'b0, 16'h7FFF);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h8000);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h7FFF);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0000);
		queue_item(mmcm_pkg::OP_MAP, 1'b1, 16'hFFFF);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h7FFE);
		// single-sample frame, zero range around 100
		queue_item(mmcm_pkg::OP_SCAN, 1'b1, 16'h0064);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0064);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0163);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0164);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h0063);
		// widen without restart
		queue_item(mmcm_pkg::OP_SCAN, 1'b0, 16'h0032);
		queue_item(mmcm_pkg::OP_SCAN, 1'b0, 16'h00C8);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h007D);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h00C7);
		queue_item(mmcm_pkg::OP_MAP, 1'b0, 16'h00C8);
		wait_drained();

		queue_random(300);
		wait_drained();

		// output held off for a long stretch while maps keep coming
		idle_on = 1'b0;
		hold_request++;
		for (i = 0; i < 24; i++)
			queue_item(mmcm_pkg::OP_MAP, 1'($urandom_range(0, 1)), SB'($urandom));
		wait_drained();

		queue_random(100);
		wait_drained();

		idle_on = 1'b1;
		queue_random(200);
		wait_drained();

		idle_on = 1'b0;
		queue_random(80);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		if (colors_due.size() != 0) begin
			errors++;
			$display("%0t: %0d expected color items never arrived", $time, colors_due.size());
		end
		$display("tb: %0d scan and %0d map items, %0d random frames plus edge cases",
			scans_taken, maps_taken, frames);
		$display("tb: %0d colors checked across idling, a long output stall and drains",
			colors_checked);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

endmodule
